// ----- design/dst_pkg.sv -----
// Shared types and constants for the descending sorted table.
// Used by dst_cell and descending_sorted_table; depends on nothing else.
package dst_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 8;
    localparam int STATUS_W      = 2;
    localparam int OUT_IDX_W     = 5;
    localparam int OUT_CNT_W     = 5;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 16;

    typedef enum logic [1:0] {
        MODE_DELETE = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_FIND   = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain in the transfer cycle.
    typedef struct packed {
        logic               del_en;
        logic               ins_en;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } cell_cmd_t;

endpackage

// ----- design/dst_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on dst_pkg.
module dst_cell #(
    parameter int INDEX = 0
) (
    input  logic                               clk,
    input  dst_pkg::cell_cmd_t                 cmd,
    input  logic                               in_range,
    input  logic                               left_qual,
    input  logic [dst_pkg::VALUE_W-1:0]        left_entry,
    input  logic [dst_pkg::VALUE_W-1:0]        right_entry,
    output logic [dst_pkg::VALUE_W-1:0]        entry,
    output logic                               qual,
    output logic                               hit
);

    localparam logic [dst_pkg::POS_W:0] POS_LIM = (dst_pkg::POS_W+1)'(INDEX + 1);

    logic [dst_pkg::VALUE_W-1:0] entry_reg;
    logic [dst_pkg::VALUE_W-1:0] entry_next;
    logic                        ge;
    logic                        eq;
    logic                        del_shift;

    assign ge        = $signed(cmd.value) >= $signed(entry_reg);
    assign eq        = cmd.value == entry_reg;
    // The new value lands in the first cell whose entry is not larger, or past the end.
    assign qual      = ge || !in_range;
    // Every earlier entry is larger, so this is the first equal entry.
    assign hit       = eq && in_range && !left_qual;
    assign del_shift = {1'b0, cmd.position} <= POS_LIM;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.del_en && del_shift)
        begin
            entry_next = right_entry;
        end
        else if (cmd.ins_en)
        begin
            if (left_qual)
            begin
                entry_next = left_entry;
            end
            else if (qual)
            begin
                entry_next = cmd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/descending_sorted_table.sv -----
// Top level of the descending sorted table: stream ports, count and result register.
// Depends on dst_pkg and dst_cell.
//
// The table is a row of TABLE_DEPTH cells, largest entry first. Each transfer carries one
// command (delete at a 1-based position, insert in order, or find a value) and produces
// exactly one result transfer. A command is finished in the cycle it is taken: all cells
// compare against the value at once and shift toward or away from their neighbors, and the
// result goes to an output register, so one command per clock is taken as long as the
// result side keeps up. An insert into a full table is dropped and reported as full.
module descending_sorted_table #(
    parameter int TABLE_DEPTH = dst_pkg::DEFAULT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] mode, [33:2] item_value, [41:34] position, [47:42] zero
    input  logic [dst_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [6:2] found_index, [11:7] entry_count, [15:12] zero
    output logic [dst_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W = 16;

    logic [1:0]                  mode;
    logic [dst_pkg::VALUE_W-1:0] item_value;
    logic [dst_pkg::POS_W-1:0]   position;
    logic                        take;
    logic                        full;
    logic                        pos_ok;
    dst_pkg::cell_cmd_t          cmd;

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    dst_pkg::status_t            status_reg;
    dst_pkg::status_t            status_next;
    logic [dst_pkg::OUT_IDX_W-1:0] found_reg;
    logic [dst_pkg::OUT_IDX_W-1:0] found_next;

    logic [dst_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      quals;
    logic [TABLE_DEPTH-1:0]      hits;
    logic [IDX_W-1:0]            hit_idx;

    assign mode       = s_tdata[1:0];
    assign item_value = s_tdata[33:2];
    assign position   = s_tdata[41:34];

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign full     = CMP_W'(count_reg) >= CMP_W'(TABLE_DEPTH);
    assign pos_ok   = (position != '0) && (CMP_W'(position) <= CMP_W'(count_reg));

    always_comb
    begin
        cmd.del_en   = take && (mode == dst_pkg::MODE_DELETE) && pos_ok;
        cmd.ins_en   = take && (mode == dst_pkg::MODE_INSERT) && !full;
        cmd.value    = item_value;
        cmd.position = position;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic                        in_range;
            logic                        left_q;
            logic [dst_pkg::VALUE_W-1:0] left_e;
            logic [dst_pkg::VALUE_W-1:0] right_e;

            assign in_range = CMP_W'(g) < CMP_W'(count_reg);

            if (g == 0)
            begin : g_first
                assign left_q = 1'b0;
                assign left_e = item_value;
            end
            else
            begin : g_mid
                assign left_q = quals[g-1];
                assign left_e = entries[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign right_e = entries[g];
            end
            else
            begin : g_inner
                assign right_e = entries[g+1];
            end

            dst_cell #(
                .INDEX(g)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .in_range    (in_range),
                .left_qual   (left_q),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (entries[g]),
                .qual        (quals[g]),
                .hit         (hits[g])
            );
        end
    endgenerate

    // At most one cell reports a hit, so its index is an OR of the hit cells' indices.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hits[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        found_next  = found_reg;
        if (take)
        begin
            status_next = dst_pkg::ST_DONE;
            found_next  = '1;
            unique case (mode)
                dst_pkg::MODE_DELETE:
                begin
                    if (pos_ok)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = dst_pkg::ST_RANGE;
                    end
                end
                dst_pkg::MODE_INSERT:
                begin
                    if (full)
                    begin
                        status_next = dst_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                dst_pkg::MODE_FIND:
                begin
                    if (|hits)
                    begin
                        found_next = dst_pkg::OUT_IDX_W'(hit_idx);
                    end
                    else
                    begin
                        status_next = dst_pkg::ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = dst_pkg::ST_DONE;
                end
            endcase
        end
    end

    assign out_valid_next = take || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, dst_pkg::OUT_CNT_W'(count_reg), found_reg, status_reg};

endmodule
